### rtl/rgb_gray_palette_quantize_pack_macros.svh
// Assertion macros for the palette quantizer checker.
// Included by files that assert; depends on nothing.
`ifndef RGB_GRAY_PALETTE_QUANTIZE_PACK_MACROS_SVH
`define RGB_GRAY_PALETTE_QUANTIZE_PACK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RGPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rgpq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RGPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rgpq assertion failed");

`endif

### rtl/rgpq_pkg.sv
// Shared types and constants for the palette quantizer.
// No dependencies; used by the luma unit and the top level.
package rgpq_pkg;

	localparam int LumaW      = 8;
	localparam int SumW       = 18;
	localparam int RecipW     = 19;
	localparam int ProdW      = SumW + RecipW;
	localparam int PalCount   = 4;
	localparam int IdxW       = 2;
	localparam int RegIdxW    = 2;
	localparam int CfgDataW   = 24;
	localparam int SlotsPerByte = 4;

	// BT.601 weights at scale 1/1000, plus the rounding half
	localparam logic [SumW-1:0] WeightR    = 18'd299;
	localparam logic [SumW-1:0] WeightG    = 18'd587;
	localparam logic [SumW-1:0] WeightB    = 18'd114;
	localparam logic [SumW-1:0] WeightHalf = 18'd500;

	// ceil(2^28 / 1000): exact floor division by 1000 for any 18-bit sum
	localparam logic [RecipW-1:0] RecipMul = 19'd268436;
	localparam int RecipShift = 28;

	// Luma of the reset palette (gray levels map to themselves)
	localparam logic [LumaW-1:0] PalLumaReset [PalCount] = '{8'd0, 8'd85, 8'd170, 8'd255};

	typedef struct packed {
		logic load_sum;
		logic load_y;
	} luma_ctl_t;

endpackage

### rtl/rgb_gray_palette_quantize_pack.sv
// Palette quantizer top level: pixel pipeline, palette luma store, 2-bit packer.
// Depends on rgpq_pkg and rgpq_luma.
//
// Usage:
//  s_* channel takes one RGB pixel per transaction; s_tlast marks the last
//  pixel of a row. m_* channel returns packed bytes of four 2-bit palette
//  indices, first pixel in bits 7:6; m_tlast marks the last byte of a row.
//  A byte leaves after every fourth pixel or at a row end (unfilled low bits 0).
//  Throughput: one pixel per clock, sustained while the output is not stalled.
//  A byte reaches m_* from the transaction of the pixel that completes it
//  through the input register, weighted sum, divide and result register.
//  Palette writes on cfg_* pass a weighted sum and a divide register before
//  they update a stored palette luma; write only while the pipeline is empty.
//  Reset clears the pipeline, the partial byte and restores the gray palette
//  0x000000, 0x555555, 0xAAAAAA, 0xFFFFFF.
//  When m_tready is low a byte in the result register holds; the pipeline
//  keeps taking pixels until all three stages are full, then s_tready drops.
module rgb_gray_palette_quantize_pack (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave pixel stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [23:0]                       s_tdata,   // red[7:0], green[15:8], blue[23:16]
	input  logic                              s_tlast,   // row_end
	// master byte stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,   // packed_byte[7:0]
	output logic                              m_tlast,   // row_last
	// configuration write port
	input  logic                              cfg_we,
	input  logic [rgpq_pkg::RegIdxW-1:0]      cfg_index,
	input  logic [rgpq_pkg::CfgDataW-1:0]     cfg_wdata
);

	logic valid1_q, valid2_q, valid3_q;
	logic out_free, en2, en3, take3;
	logic [7:0] red_s1, green_s1, blue_s1;
	logic last_s1, last_s2, last_s3;
	logic [rgpq_pkg::LumaW-1:0] y_s3;
	rgpq_pkg::luma_ctl_t pix_ctl, cfg_ctl;

	logic cfg_pend_s1, cfg_pend_s2;
	logic [rgpq_pkg::RegIdxW-1:0] cfg_idx_s1, cfg_idx_s2;
	logic [rgpq_pkg::LumaW-1:0] cfg_luma;
	logic [rgpq_pkg::LumaW-1:0] pal_luma_q [rgpq_pkg::PalCount];

	logic [rgpq_pkg::LumaW-1:0] gap [rgpq_pkg::PalCount];
	logic [rgpq_pkg::LumaW-1:0] best_gap;
	logic [rgpq_pkg::IdxW-1:0]  best_idx;

	logic [5:0] partial_q;
	logic [1:0] slot_q;
	logic [7:0] acc;
	logic       emit;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	// stage advance: a stage loads when it is empty or its content moves on
	assign out_free = !out_valid_q || m_tready;
	assign en3      = !valid3_q || out_free;
	assign en2      = !valid2_q || en3;
	assign s_tready = !valid1_q || en2;
	assign take3    = valid3_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid1_q <= 1'b0;
			valid2_q <= 1'b0;
			valid3_q <= 1'b0;
		end else begin
			if (s_tready) valid1_q <= s_tvalid;
			if (en2)      valid2_q <= valid1_q;
			if (en3)      valid3_q <= valid2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			red_s1   <= s_tdata[7:0];
			green_s1 <= s_tdata[15:8];
			blue_s1  <= s_tdata[23:16];
			last_s1  <= s_tlast;
		end
		if (en2) last_s2 <= last_s1;
		if (en3) last_s3 <= last_s2;
	end

	assign pix_ctl.load_sum = en2;
	assign pix_ctl.load_y   = en3;

	rgpq_luma u_pix_luma (
		.clk   (clk),
		.ctl   (pix_ctl),
		.red   (red_s1),
		.green (green_s1),
		.blue  (blue_s1),
		.luma  (y_s3)
	);

	// palette writes go through their own luma unit; only the luma is kept
	assign cfg_ctl.load_sum = cfg_we;
	assign cfg_ctl.load_y   = cfg_pend_s1;

	rgpq_luma u_cfg_luma (
		.clk   (clk),
		.ctl   (cfg_ctl),
		.red   (cfg_wdata[23:16]),
		.green (cfg_wdata[15:8]),
		.blue  (cfg_wdata[7:0]),
		.luma  (cfg_luma)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_pend_s1 <= 1'b0;
			cfg_pend_s2 <= 1'b0;
		end else begin
			cfg_pend_s1 <= cfg_we;
			cfg_pend_s2 <= cfg_pend_s1;
		end
	end

	always_ff @(posedge clk) begin
		cfg_idx_s1 <= cfg_index;
		cfg_idx_s2 <= cfg_idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_luma_q <= rgpq_pkg::PalLumaReset;
		end else if (cfg_pend_s2) begin
			pal_luma_q[cfg_idx_s2] <= cfg_luma;
		end
	end

	always_comb begin
		for (int i = 0; i < rgpq_pkg::PalCount; i++) begin
			gap[i] = (pal_luma_q[i] > y_s3) ? (pal_luma_q[i] - y_s3) : (y_s3 - pal_luma_q[i]);
		end
	end

	// strict less-than keeps the lower index on ties
	always_comb begin
		best_idx = '0;
		best_gap = gap[0];
		for (int i = 1; i < rgpq_pkg::PalCount; i++) begin
			if (gap[i] < best_gap) begin
				best_gap = gap[i];
				best_idx = rgpq_pkg::IdxW'(i);
			end
		end
	end

	assign acc  = {partial_q, best_idx};
	assign emit = (slot_q == 2'(rgpq_pkg::SlotsPerByte - 1)) || last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			slot_q    <= '0;
		end else if (take3) begin
			if (emit) begin
				partial_q <= '0;
				slot_q    <= '0;
			end else begin
				partial_q <= acc[5:0];
				slot_q    <= slot_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take3 && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// left-align the collected indices; shift is 2 * (3 - slot)
	always_ff @(posedge clk) begin
		if (take3 && emit) begin
			out_byte_q <= 8'(acc << {~slot_q, 1'b0});
			out_last_q <= last_s3;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

endmodule

### rtl/rgpq_luma.sv
// Two-stage BT.601 luma unit: weighted sum, then rounding divide by 1000.
// Depends on rgpq_pkg.
module rgpq_luma (
	input  logic                         clk,
	input  rgpq_pkg::luma_ctl_t          ctl,
	input  logic [7:0]                   red,
	input  logic [7:0]                   green,
	input  logic [7:0]                   blue,
	output logic [rgpq_pkg::LumaW-1:0]   luma
);

	logic [rgpq_pkg::SumW-1:0]  wsum;
	logic [rgpq_pkg::SumW-1:0]  sum_s1;
	logic [rgpq_pkg::ProdW-1:0] prod;
	logic [rgpq_pkg::LumaW-1:0] luma_s2;

	// max 255000 + 500 still fits 18 bits
	assign wsum = ({10'd0, red} * rgpq_pkg::WeightR) + ({10'd0, green} * rgpq_pkg::WeightG)
		+ ({10'd0, blue} * rgpq_pkg::WeightB) + rgpq_pkg::WeightHalf;

	always_ff @(posedge clk) begin
		if (ctl.load_sum) begin
			sum_s1 <= wsum;
		end
	end

	assign prod = {{rgpq_pkg::RecipW{1'b0}}, sum_s1}
		* {{rgpq_pkg::SumW{1'b0}}, rgpq_pkg::RecipMul};

	always_ff @(posedge clk) begin
		if (ctl.load_y) begin
			luma_s2 <= prod[rgpq_pkg::RecipShift +: rgpq_pkg::LumaW];
		end
	end

	assign luma = luma_s2;

endmodule

### rtl/rgpq_checker.sv
// Port-level checker for the palette quantizer, bound to the top level.
// Depends on rgb_gray_palette_quantize_pack_macros.svh.
`include "rgb_gray_palette_quantize_pack_macros.svh"

module rgpq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	logic out_stall;

	assign out_stall = m_tvalid && !m_tready;

	// hold a stalled result transaction
	`RGPQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_tvalid && $stable({m_tdata, m_tlast}))

	// back-pressure on the input only ever comes from a stalled output
	`RGPQ_ASSERT_IMPL(a_stall_source, clk, arst_n, !s_tready, out_stall)

	// an empty result register never blocks the input
	`RGPQ_ASSERT_IMPL(a_empty_ready, clk, arst_n, !m_tvalid, s_tready)

endmodule

bind rgb_gray_palette_quantize_pack rgpq_checker u_rgpq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
